[design/dbsmlc_pkg.sv]
`timescale 1ns / 1ps
package dbsmlc_pkg;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int SMOOTH_W = 20;
   localparam int OFFSET_W = 16;
   localparam int CODE_W   = 8;
   localparam int RATIO_W  = 17;
   localparam int MAG_W    = 20;
   localparam int MUL_A_W  = 21;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int OSUM_W   = OFFSET_W + 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_WEIGHT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANK1_TARGET    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANK2_TARGET    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_GAIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAC_FLOOR       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAC_CEILING     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIFT_THRESHOLD = 3'd7;

   // smoothed reading after reset: 0.5 V of a 3.3 V full scale, Q12.8 counts
   localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 20'd158836;

   // restoring divider yields one quotient bit per step
   localparam int DIV_STEPS = RATIO_W;
   localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_bank1;
      logic [SAMPLE_W-1:0] sample_bank2;
   } req_word_type;

   typedef struct packed {
      logic [CODE_W-1:0] dac_code_bank1;
      logic [CODE_W-1:0] dac_code_bank2;
      logic              asym_drive;
      logic              asym_level;
      logic              limit_drive;
      logic              limit_level;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0]         smooth_weight;
      logic [SAMPLE_W-1:0] bank1_target;
      logic [SAMPLE_W-1:0] bank2_target;
      logic [15:0]         control_gain;
      logic [SAMPLE_W-1:0] boundary_width;
      logic [CODE_W-1:0]   dac_floor;
      logic [CODE_W-1:0]   dac_ceiling;
      logic [15:0]         drift_threshold;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SM_MUL,
      OP_SM_ADD,
      OP_ERR,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_GAIN_MUL,
      OP_STEP,
      OP_CLAMP,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      bank;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic div_sat;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SM_MUL,
      ST_SM_ADD,
      ST_ERR,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_GAIN_MUL,
      ST_STEP,
      ST_CLAMP,
      ST_EMIT
   } ctrl_state_type;

endpackage

[design/dbsmlc_ctrl.sv]
`timescale 1ns / 1ps
module dbsmlc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dbsmlc_pkg::dp_status_type status,
   output dbsmlc_pkg::dp_cmd_type    cmd
);
   import dbsmlc_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   ctrl_state_type   state_ff, state_in;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bank_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         cnt_ff   <= cnt_in;
      end
   end

   // sequencing: two banks, each smooth, error, divide, gain, offset update
   always_comb begin
      state_in = state_ff;
      bank_in  = bank_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      cmd.bank = bank_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               bank_in  = 1'b0;
               state_in = ST_SM_MUL;
            end
         end
         ST_SM_MUL: begin
            cmd.op   = OP_SM_MUL;
            state_in = ST_SM_ADD;
         end
         ST_SM_ADD: begin
            cmd.op   = OP_SM_ADD;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.op   = OP_ERR;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            // a saturated ratio needs no quotient
            if (status.div_sat) begin
               state_in = ST_GAIN_MUL;
            end else begin
               cmd.op = OP_DIV_STEP;
               if (cnt_ff == CNT_LAST) begin
                  state_in = ST_GAIN_MUL;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_GAIN_MUL: begin
            cmd.op   = OP_GAIN_MUL;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.op   = OP_STEP;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.op = OP_CLAMP;
            if (bank_ff) begin
               state_in = ST_EMIT;
            end else begin
               bank_in  = 1'b1;
               state_in = ST_SM_MUL;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // an accepted word always starts with bank one smoothing
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SM_MUL && !bank_ff))
      else $error("accepted word did not start bank one");

   // gain multiply only follows the divider
   a_gain_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN_MUL) |-> ($past(state_ff) == ST_DIV_STEP))
      else $error("gain multiply entered without divide");

endmodule

[design/dbsmlc_dp.sv]
`timescale 1ns / 1ps
module dbsmlc_dp #(
   parameter logic [7:0] DAC_MID_CODE = 8'd128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dbsmlc_pkg::cfg_type      cfg,
   input  dbsmlc_pkg::dp_cmd_type   cmd,
   output dbsmlc_pkg::dp_status_type status,
   input  dbsmlc_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dbsmlc_pkg::rsp_word_type rsp_word
);
   import dbsmlc_pkg::*;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = {DAC_MID_CODE, 8'h00};

   // bank state and working registers
   logic [1:0][SAMPLE_W-1:0] sample_ff, sample_in;
   logic [1:0][SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic [1:0][OFFSET_W-1:0] offset_ff, offset_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic                     sat_ff, sat_in;
   logic [SAMPLE_W-1:0]      rem_ff, rem_in;
   logic [RATIO_W-1:0]       quo_ff, quo_in;
   logic signed [OSUM_W-1:0] osum_ff, osum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   // combinational helpers
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [PROD_W-1:0]  acc;
   logic signed [MUL_A_W-1:0] err;
   logic [SAMPLE_W-1:0]       target;
   logic [SAMPLE_W-1:0]       bw_eff;
   logic [SAMPLE_W:0]         trial;
   logic [RATIO_W-1:0]        ratio;
   logic [31:0]               dsum;
   logic signed [OSUM_W-1:0]  off_ext;
   logic signed [OSUM_W-1:0]  d_ext;
   logic signed [OSUM_W-1:0]  lo_ext;
   logic signed [OSUM_W-1:0]  hi_ext;
   logic [OFFSET_W-1:0]       clamp_val;
   logic signed [OFFSET_W:0]  drift;
   logic [OFFSET_W-1:0]       adrift;
   logic [CODE_W-1:0]         code1;
   logic [CODE_W-1:0]         code2;
   logic                      asym;
   logic                      high;
   logic                      lim;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign status.out_free = out_free;
   assign status.div_sat  = sat_ff;

   // zero width acts as one count
   assign bw_eff = (cfg.boundary_width == '0) ? SAMPLE_W'(1) : cfg.boundary_width;
   assign target = cmd.bank ? cfg.bank2_target : cfg.bank1_target;

   // shared multiplier: smoothing weight or gain times ratio
   assign ratio = sat_ff ? RATIO_ONE : ((quo_ff > RATIO_ONE) ? RATIO_ONE : quo_ff);
   always_comb begin
      if (cmd.op == OP_GAIN_MUL) begin
         mul_a = $signed({4'b0000, ratio});
         mul_b = $signed({1'b0, cfg.control_gain});
      end else begin
         mul_a = $signed({1'b0, sample_ff[cmd.bank], 8'h00})
               - $signed({1'b0, smooth_ff[cmd.bank]});
         mul_b = $signed({1'b0, cfg.smooth_weight});
      end
   end
   assign mul_p = mul_a * mul_b;

   // smoothed value: weighted difference plus old value, rounded
   assign acc = prod_ff + $signed({2'b00, smooth_ff[cmd.bank], 16'h8000});

   // error to target in Q12.8
   assign err = $signed({1'b0, target, 8'h00}) - $signed({1'b0, smooth_ff[cmd.bank]});

   // one restoring divide step
   assign trial = {rem_ff, quo_ff[RATIO_W-1]};

   // rounded step and raw offset update
   assign dsum    = prod_ff[31:0] + 32'h0000_8000;
   assign off_ext = $signed({2'b00, offset_ff[cmd.bank]});
   assign d_ext   = $signed({2'b00, dsum[31:16]});

   // clamp to floor first, then ceiling
   assign lo_ext = $signed({2'b00, cfg.dac_floor, 8'h00});
   assign hi_ext = $signed({2'b00, cfg.dac_ceiling, 8'h00});
   always_comb begin
      if (osum_ff < lo_ext) begin
         clamp_val = {cfg.dac_floor, 8'h00};
      end else if (osum_ff > hi_ext) begin
         clamp_val = {cfg.dac_ceiling, 8'h00};
      end else begin
         clamp_val = osum_ff[OFFSET_W-1:0];
      end
   end

   // output flags from both offsets
   assign code1  = offset_ff[0][OFFSET_W-1:8];
   assign code2  = offset_ff[1][OFFSET_W-1:8];
   assign drift  = $signed({1'b0, offset_ff[0]}) - $signed({1'b0, offset_ff[1]});
   assign adrift = drift[OFFSET_W] ? OFFSET_W'(-drift) : drift[OFFSET_W-1:0];
   assign asym   = adrift > cfg.drift_threshold;
   assign high   = (code1 >= cfg.dac_ceiling) || (code2 >= cfg.dac_ceiling);
   assign lim    = high || (code1 <= cfg.dac_floor) || (code2 <= cfg.dac_floor);

   // next values per command
   always_comb begin
      sample_in    = sample_ff;
      smooth_in    = smooth_ff;
      offset_in    = offset_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      osum_in      = osum_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cmd.op)
         OP_LOAD: begin
            sample_in[0] = req_word.sample_bank1;
            sample_in[1] = req_word.sample_bank2;
         end
         OP_SM_MUL: begin
            prod_in = mul_p;
         end
         OP_SM_ADD: begin
            smooth_in[cmd.bank] = acc[35:16];
         end
         OP_ERR: begin
            neg_in = err[MUL_A_W-1];
            mag_in = err[MUL_A_W-1] ? MAG_W'(-err) : err[MAG_W-1:0];
         end
         OP_DIV_INIT: begin
            sat_in = ({1'b0, mag_ff[MAG_W-1:9]} >= bw_eff);
            rem_in = {1'b0, mag_ff[MAG_W-1:9]};
            quo_in = {mag_ff[8:0], 8'h00};
         end
         OP_DIV_STEP: begin
            if (trial >= {1'b0, bw_eff}) begin
               rem_in = SAMPLE_W'(trial - {1'b0, bw_eff});
               quo_in = {quo_ff[RATIO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[SAMPLE_W-1:0];
               quo_in = {quo_ff[RATIO_W-2:0], 1'b0};
            end
         end
         OP_GAIN_MUL: begin
            prod_in = mul_p;
         end
         OP_STEP: begin
            osum_in = neg_ff ? (off_ext - d_ext) : (off_ext + d_ext);
         end
         OP_CLAMP: begin
            offset_in[cmd.bank] = clamp_val;
         end
         OP_EMIT: begin
            rsp_valid_in               = 1'b1;
            rsp_word_in.dac_code_bank1 = code1;
            rsp_word_in.dac_code_bank2 = code2;
            rsp_word_in.asym_drive     = asym;
            rsp_word_in.asym_level     = asym && !drift[OFFSET_W];
            rsp_word_in.limit_drive    = lim;
            rsp_word_in.limit_level    = lim && high;
         end
         default: begin
         end
      endcase
   end

   // model state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff    <= {SMOOTH_RESET, SMOOTH_RESET};
         offset_ff    <= {OFFSET_RESET, OFFSET_RESET};
         rsp_valid_ff <= 1'b0;
      end else begin
         smooth_ff    <= smooth_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      prod_ff     <= prod_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      osum_ff     <= osum_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a result is only loaded into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> out_free)
      else $error("result overwrote a pending word");

   // divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_STEP && !sat_ff) |-> (rem_ff < bw_eff))
      else $error("divider remainder out of range");

   // clamped offset lies between the bounds when they are ordered
   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_CLAMP && cfg.dac_floor <= cfg.dac_ceiling) |->
      (clamp_val >= {cfg.dac_floor, 8'h00} && clamp_val <= {cfg.dac_ceiling, 8'h00}))
      else $error("clamped offset outside dac bounds");

endmodule

[design/dual_bank_sliding_mode_lambda_ctrl.sv]
`timescale 1ns / 1ps
// Dual-bank sliding-mode lambda controller. Each request word carries one
// 12-bit oxygen-sensor sample per bank; the block smooths each bank, forms the
// boundary-layer ratio of its error from the bank target to the boundary
// width, scales it by the gain into a Q8.8 offset clamped to the DAC bounds,
// and returns one response word with both DAC codes and the asymmetry and
// limit lines. Words are processed one at a time by a controller stepping a
// datapath with one shared multiplier and a one-bit-per-cycle divider; a
// saturated ratio skips the 17-step divide, which is the dominant term in the
// time from acceptance to the response register. A new word is taken once
// the previous one has been loaded into the output register; the response
// waits there until taken. Registers must be written through the csr port
// only while no word is in flight; the block itself does not enforce this.
module dual_bank_sliding_mode_lambda_ctrl #(
   parameter logic [7:0] DAC_MID_CODE = 8'd128
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  dbsmlc_pkg::req_word_type                 req_word,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output dbsmlc_pkg::rsp_word_type                 rsp_word,
   input  logic                                     csr_wr_en,
   input  logic [dbsmlc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [dbsmlc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import dbsmlc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type status;

   // register writes, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SMOOTH_WEIGHT:   cfg_in.smooth_weight   = csr_wdata;
            CSR_BANK1_TARGET:    cfg_in.bank1_target    = csr_wdata[SAMPLE_W-1:0];
            CSR_BANK2_TARGET:    cfg_in.bank2_target    = csr_wdata[SAMPLE_W-1:0];
            CSR_CONTROL_GAIN:    cfg_in.control_gain    = csr_wdata;
            CSR_BOUNDARY_WIDTH:  cfg_in.boundary_width  = csr_wdata[SAMPLE_W-1:0];
            CSR_DAC_FLOOR:       cfg_in.dac_floor       = csr_wdata[CODE_W-1:0];
            CSR_DAC_CEILING:     cfg_in.dac_ceiling     = csr_wdata[CODE_W-1:0];
            CSR_DRIFT_THRESHOLD: cfg_in.drift_threshold = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smooth_weight   <= 16'd16384;
         cfg_ff.bank1_target    <= 12'd2048;
         cfg_ff.bank2_target    <= 12'd2048;
         cfg_ff.control_gain    <= 16'd256;
         cfg_ff.boundary_width  <= 12'd64;
         cfg_ff.dac_floor       <= 8'd0;
         cfg_ff.dac_ceiling     <= 8'd255;
         cfg_ff.drift_threshold <= 16'd5120;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   dbsmlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   dbsmlc_dp #(
      .DAC_MID_CODE (DAC_MID_CODE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
   import dbsmlc_pkg::*;

   localparam logic [CODE_W-1:0] MID_CODE = 8'd128;
   localparam int QUIET_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 17;
   localparam int PHASE_WORDS    = 100;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {
      STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY
   } stall_mode_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      req_word_type           word;
      logic                   has_result;
      rsp_word_type           result;
   } dir_row_type;

   // directed rows; register fields unused on word rows, word unused on csr rows
   localparam int DIR_ROWS = 32;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd0, 12'd0}, 1'b1, {8'd129, 8'd129, 4'b0000}},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd4095, 12'd4095}, 1'b1,
        {8'd130, 8'd130, 4'b0000}},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd4095, 12'd0}, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd0, 12'd4095}, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd2048, 12'd2048}, 1'b0, 20'd0},
      '{ROW_CSR, CSR_BOUNDARY_WIDTH, 16'd0, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_CONTROL_GAIN, 16'd65535, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_SMOOTH_WEIGHT, 16'd65535, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_BANK1_TARGET, 16'd0, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_BANK2_TARGET, 16'd0, 24'd0, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd4095, 12'd4095}, 1'b1,
        {8'd0, 8'd0, 4'b0010}},
      '{ROW_CSR, CSR_BANK1_TARGET, 16'd4095, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_BANK2_TARGET, 16'd4095, 24'd0, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd0, 12'd0}, 1'b1, {8'd255, 8'd255, 4'b0011}},
      '{ROW_CSR, CSR_DRIFT_THRESHOLD, 16'd0, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_BANK2_TARGET, 16'd0, 24'd0, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd0, 12'd0}, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd4095, 12'd4095}, 1'b1,
        {8'd255, 8'd0, 4'b1111}},
      '{ROW_CSR, CSR_DRIFT_THRESHOLD, 16'd65535, 24'd0, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd0, 12'd4095}, 1'b0, 20'd0},
      '{ROW_CSR, CSR_DAC_FLOOR, 16'd200, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_DAC_CEILING, 16'd50, 24'd0, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd2048, 12'd2048}, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd0, 12'd0}, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd4095, 12'd4095}, 1'b0, 20'd0},
      '{ROW_CSR, CSR_DRIFT_THRESHOLD, 16'd5120, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_SMOOTH_WEIGHT, 16'd0, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_CONTROL_GAIN, 16'd300, 24'd0, 1'b0, 20'd0},
      '{ROW_CSR, CSR_BOUNDARY_WIDTH, 16'd4095, 24'd0, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd4095, 12'd0}, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd1234, 12'd2345}, 1'b0, 20'd0},
      '{ROW_WORD, CSR_SMOOTH_WEIGHT, 16'd0, {12'd2730, 12'd1365}, 1'b0, 20'd0}
   };

   localparam logic [CSR_INDEX_W-1:0] REG_ORDER [8] = '{
      CSR_SMOOTH_WEIGHT, CSR_BANK1_TARGET, CSR_BANK2_TARGET, CSR_CONTROL_GAIN,
      CSR_BOUNDARY_WIDTH, CSR_DAC_FLOOR, CSR_DAC_CEILING, CSR_DRIFT_THRESHOLD
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_word_type           req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_word_type           rsp_word;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // predictor copy of the registers and the per-bank state
   cfg_type               csr_shadow;
   logic [SMOOTH_W-1:0]   filt_b1, filt_b2;
   logic [OFFSET_W-1:0]   trim_b1, trim_b2;

   rsp_word_type pending_dac_q [$];
   int           mismatch_count = 0;
   int unsigned  burst_left = 0;
   int unsigned  idle_cycles = 0;

   dual_bank_sliding_mode_lambda_ctrl #(
      .DAC_MID_CODE(MID_CODE)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // exponential average of one bank, rounded
   function automatic logic [SMOOTH_W-1:0] smooth_next(input logic [SMOOTH_W-1:0] s,
                                                       input logic [SAMPLE_W-1:0] sample);
      logic [63:0] acc;
      acc = 64'(sample) * 64'd256 * 64'(csr_shadow.smooth_weight)
          + 64'(s) * (64'd65536 - 64'(csr_shadow.smooth_weight)) + 64'd32768;
      return acc[35:16];
   endfunction

   // boundary-layer ratio, gain step and clamped offset of one bank
   function automatic logic [OFFSET_W-1:0] offset_next(input logic [OFFSET_W-1:0] off,
                                                       input logic [SMOOTH_W-1:0] sm,
                                                       input logic [SAMPLE_W-1:0] target);
      longint err, o, lo, hi;
      longint unsigned mag, bw, ratio, dstep;
      err = longint'(target) * 256 - longint'(sm);
      mag = (err < 0) ? -err : err;
      bw = (csr_shadow.boundary_width == '0) ? 1 : csr_shadow.boundary_width;
      ratio = (mag << 8) / bw;
      if (ratio > 65536) ratio = 65536;
      dstep = (csr_shadow.control_gain * ratio + 32768) >> 16;
      o = longint'(off) + ((err < 0) ? -longint'(dstep) : longint'(dstep));
      lo = longint'(csr_shadow.dac_floor) * 256;
      hi = longint'(csr_shadow.dac_ceiling) * 256;
      // floor test first, so a floor above the ceiling wins only from below
      if (o < lo) o = lo;
      else if (o > hi) o = hi;
      return o[15:0];
   endfunction

   // advance both banks by one word and form the dac word
   function automatic rsp_word_type next_dac_word(input req_word_type w);
      rsp_word_type r;
      longint drift, adrift;
      logic high, lim;
      filt_b1 = smooth_next(filt_b1, w.sample_bank1);
      filt_b2 = smooth_next(filt_b2, w.sample_bank2);
      trim_b1 = offset_next(trim_b1, filt_b1, csr_shadow.bank1_target);
      trim_b2 = offset_next(trim_b2, filt_b2, csr_shadow.bank2_target);
      r.dac_code_bank1 = trim_b1[15:8];
      r.dac_code_bank2 = trim_b2[15:8];
      drift = longint'(trim_b1) - longint'(trim_b2);
      adrift = (drift < 0) ? -drift : drift;
      r.asym_drive = (adrift > longint'(csr_shadow.drift_threshold));
      r.asym_level = r.asym_drive && (drift > 0);
      high = (r.dac_code_bank1 >= csr_shadow.dac_ceiling)
          || (r.dac_code_bank2 >= csr_shadow.dac_ceiling);
      lim = high || (r.dac_code_bank1 <= csr_shadow.dac_floor)
          || (r.dac_code_bank2 <= csr_shadow.dac_floor);
      r.limit_drive = lim;
      r.limit_level = lim && high;
      return r;
   endfunction

   // random register value, extremes and out-of-range upper bits included
   function automatic logic [CSR_DATA_W-1:0] pick_setting(input logic [CSR_INDEX_W-1:0] idx);
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return '0;
      case (idx)
         CSR_SMOOTH_WEIGHT:
            return (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
         CSR_BANK1_TARGET, CSR_BANK2_TARGET:
            return (roll == 1) ? 16'd4095 :
                   (roll == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 4095));
         CSR_CONTROL_GAIN:
            return (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 1024));
         CSR_BOUNDARY_WIDTH:
            return (roll == 1) ? 16'd4095 : (roll == 2) ? 16'($urandom_range(0, 65535)) :
                   (roll == 3) ? 16'd1 : 16'($urandom_range(1, 512));
         CSR_DAC_FLOOR:
            return (roll == 1) ? 16'd255 :
                   (roll == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 100));
         CSR_DAC_CEILING:
            return (roll == 1) ? 16'd255 :
                   (roll == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(150, 255));
         default:
            return (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 20000));
      endcase
   endfunction

   // sample mostly inside the boundary layer around the target
   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] target);
      int spread, v;
      spread = int'(csr_shadow.boundary_width) + 8;
      case ($urandom_range(0, 9))
         0, 1: v = int'($urandom_range(0, 4095));
         2: v = ($urandom_range(0, 1) == 0) ? 0 : 4095;
         default: v = int'(target) + int'($urandom_range(0, 2 * spread)) - spread;
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[SAMPLE_W-1:0];
   endfunction

   // one register write; the caller lowers the enable after the group
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SMOOTH_WEIGHT:   csr_shadow.smooth_weight   = value;
         CSR_BANK1_TARGET:    csr_shadow.bank1_target    = value[SAMPLE_W-1:0];
         CSR_BANK2_TARGET:    csr_shadow.bank2_target    = value[SAMPLE_W-1:0];
         CSR_CONTROL_GAIN:    csr_shadow.control_gain    = value;
         CSR_BOUNDARY_WIDTH:  csr_shadow.boundary_width  = value[SAMPLE_W-1:0];
         CSR_DAC_FLOOR:       csr_shadow.dac_floor       = value[CODE_W-1:0];
         CSR_DAC_CEILING:     csr_shadow.dac_ceiling     = value[CODE_W-1:0];
         CSR_DRIFT_THRESHOLD: csr_shadow.drift_threshold = value;
      endcase
      @(posedge clock);
   endtask

   // send one word in bursts with random gaps, queue its expected result
   task automatic push_word(input req_word_type w, input logic typed,
                            input rsp_word_type typed_result);
      rsp_word_type predicted;
      csr_wr_en <= 1'b0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clock);
         end
      end
      burst_left--;
      predicted = next_dac_word(w);
      pending_dac_q.push_back(typed ? typed_result : predicted);
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and let every outstanding word come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_dac_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // stimulus: directed table, then random phases of settings
   initial begin : stimulus
      logic csr_open;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_SMOOTH_WEIGHT;
      csr_wdata <= '0;
      csr_open = 1'b0;
      csr_shadow = '{smooth_weight: 16'd16384, bank1_target: 12'd2048,
                     bank2_target: 12'd2048, control_gain: 16'd256,
                     boundary_width: 12'd64, dac_floor: 8'd0,
                     dac_ceiling: 8'd255, drift_threshold: 16'd5120};
      filt_b1 = SMOOTH_RESET;
      filt_b2 = SMOOTH_RESET;
      trim_b1 = {MID_CODE, 8'h00};
      trim_b2 = {MID_CODE, 8'h00};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            if (!csr_open) settle();
            write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
            csr_open = 1'b1;
         end else begin
            push_word(DIRECTED[i].word, DIRECTED[i].has_result, DIRECTED[i].result);
            csr_open = 1'b0;
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         for (int k = 0; k < $size(REG_ORDER); k++)
            write_reg(REG_ORDER[k], pick_setting(REG_ORDER[k]));
         repeat (PHASE_WORDS)
            push_word({pick_sample(csr_shadow.bank1_target),
                       pick_sample(csr_shadow.bank2_target)}, 1'b0, '0);
      end

      settle();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // receiver stall pattern in randomly chosen modes
   initial begin : rsp_pacing
      stall_mode_type mode;
      int unsigned tick;
      rsp_stall <= 1'b0;
      tick = 0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         repeat ($urandom_range(20, 300)) begin
            @(posedge clock);
            tick++;
            case (mode)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_COIN:     rsp_stall <= ($urandom_range(0, 1) == 0);
               STALL_PERIODIC: rsp_stall <= ((tick % 5) < 2);
               STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   // compare each accepted dac word with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dac_q.size() == 0) begin
            $display("%0t: response word %h with nothing expected", $time, rsp_word);
            mismatch_count++;
         end else begin
            want = pending_dac_q.pop_front();
            check_field("dac_code_bank1", want.dac_code_bank1, rsp_word.dac_code_bank1);
            check_field("dac_code_bank2", want.dac_code_bank2, rsp_word.dac_code_bank2);
            check_field("asym_drive", want.asym_drive, rsp_word.asym_drive);
            check_field("asym_level", want.asym_level, rsp_word.asym_level);
            check_field("limit_drive", want.limit_drive, rsp_word.limit_drive);
            check_field("limit_level", want.limit_level, rsp_word.limit_level);
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

[dual_bank_sliding_mode_lambda_ctrl.f]
design/dbsmlc_pkg.sv
design/dbsmlc_ctrl.sv
design/dbsmlc_dp.sv
design/dual_bank_sliding_mode_lambda_ctrl.sv
bench/tb.sv
